// ===== design/lgts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_pkg
// shared types and constants of the lda gibbs topic sampler
// ----------------------------------------------------------------------------
package lgts_pkg;

  localparam int NumTopicsW = 8;
  localparam int VocabW     = 17;
  localparam int PriorW     = 24;
  localparam int DocIdxW    = 12;
  localparam int WordIdW    = 16;
  localparam int TopicW     = 7;
  localparam int RandW      = 31;
  localparam int CumW       = 40;
  localparam int WeightW    = 32;
  localparam int CfgIdxW    = 2;
  localparam int InDataW    = 72;
  localparam int OutDataW   = 8;

  localparam logic [NumTopicsW-1:0] NumTopicsRst = 8'd100;
  localparam logic [VocabW-1:0]     VocabRst     = 17'd65536;
  localparam logic [PriorW-1:0]     AlphaRst     = 24'd32768;
  localparam logic [PriorW-1:0]     BetaRst      = 24'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_TOPICS = 2'd0,
    CFG_VOCAB_SIZE = 2'd1,
    CFG_ALPHA      = 2'd2,
    CFG_BETA       = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REDUCE,
    CMD_ADJ_RD,
    CMD_DEC_WR,
    CMD_INC_WR,
    CMD_W_RD,
    CMD_W_LOAD,
    CMD_W_MUL,
    CMD_W_CHK,
    CMD_W_DIV,
    CMD_W_ACC,
    CMD_R_MUL0,
    CMD_R_MUL1,
    CMD_S_RD,
    CMD_S_CMP,
    CMD_OUT
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
  } dp_ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic reduce_done;
    logic resample;
    logic mul_done;
    logic div_done;
    logic k_last;
    logic found;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/lgts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module lgts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lgts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_datapath
// count tables, weight multiply and divide, cumulative search, output register
// ----------------------------------------------------------------------------
module lgts_datapath
  import lgts_pkg::*;
#(
  parameter int TOPICS_MAX = 128,
  parameter int VOCAB_MAX  = 65536,
  parameter int DOCS_MAX   = 4096,
  parameter int COUNT_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PriorW-1:0]   cfg_data_i,
  input  logic                op_i,
  input  logic [DocIdxW-1:0]  doc_index_i,
  input  logic [WordIdW-1:0]  word_id_i,
  input  logic [TopicW-1:0]   old_topic_i,
  input  logic [RandW-1:0]    rand_value_i,
  input  dp_ctrl_t            ctrl_i,
  output dp_stat_t            stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TopicW-1:0]   new_topic_o
);

  localparam int TW     = $clog2(TOPICS_MAX);
  localparam int KW     = TW + 1;
  localparam int VW     = (VOCAB_MAX > 1) ? $clog2(VOCAB_MAX) : 1;
  localparam int DW     = (DOCS_MAX > 1) ? $clog2(DOCS_MAX) : 1;
  localparam int CLR_A  = (VOCAB_MAX > DOCS_MAX) ? VOCAB_MAX : DOCS_MAX;
  localparam int CLR_N  = (CLR_A > TOPICS_MAX) ? CLR_A : TOPICS_MAX;
  localparam int CLRW   = $clog2(CLR_N) + 1;
  localparam int CW     = COUNT_BITS;
  localparam int ROWW   = TOPICS_MAX * CW;
  localparam int AW     = CW + 17;
  localparam int PW     = 2 * AW;
  localparam int NCH    = (AW + 15) / 16;
  localparam int JW     = $clog2(NCH + 1);
  localparam int VBW    = VocabW + PriorW;
  localparam int DENW   = ((CW + 16 > VBW) ? CW + 16 : VBW) + 1;
  localparam int CMPW   = PW + DENW + 24;
  localparam int UPW    = RandW + CumW;

  // configuration
  logic [NumTopicsW-1:0] ntop_q;
  logic [VocabW-1:0]     vocab_q;
  logic [PriorW-1:0]     alpha_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ntop_q  <= NumTopicsRst;
      vocab_q <= VocabRst;
      alpha_q <= AlphaRst;
      beta_q  <= BetaRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_TOPICS: ntop_q  <= cfg_data_i[NumTopicsW-1:0];
        CFG_VOCAB_SIZE: vocab_q <= cfg_data_i[VocabW-1:0];
        CFG_ALPHA:      alpha_q <= cfg_data_i;
        CFG_BETA:       beta_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  logic [KW-1:0] k_eff;
  logic [TW-1:0] klast;

  always_comb begin
    if (ntop_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(ntop_q) > TOPICS_MAX) begin
      k_eff = KW'(TOPICS_MAX);
    end else begin
      k_eff = KW'(ntop_q);
    end
    klast = TW'(k_eff - KW'(1));
  end

  // clearing pass
  logic [CLRW-1:0] clr_q;
  logic            clr_done_q;
  logic            clearing;

  assign clearing = !clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (clearing) begin
      clr_q <= clr_q + CLRW'(1);
      if (32'(clr_q) == CLR_N - 1) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  // working registers
  dp_cmd_e cmd;
  logic                op_q;
  logic [DocIdxW-1:0]  doc_q;
  logic [WordIdW-1:0]  word_q;
  logic [TW-1:0]       topic_q;
  logic [TW-1:0]       k_q;
  logic [RandW-1:0]    rnd_q;
  logic [VBW-1:0]      vbeta_q;
  logic [AW-1:0]       a_q, b_q;
  logic [DENW-1:0]     den_q, r_q;
  logic [PW-1:0]       p_q;
  logic [JW-1:0]       j_q;
  logic [4:0]          st_q;
  logic [WeightW-1:0]  qsh_q;
  logic                sat_q;
  logic [CumW-1:0]     acc_q;
  logic [UPW-1:0]      up_q;
  logic                out_valid_q;
  logic [TopicW-1:0]   out_topic_q;

  assign cmd = ctrl_i.cmd;

  logic [DW-1:0] doc_ix;
  logic [VW-1:0] word_ix;
  assign doc_ix  = DW'(doc_q);
  assign word_ix = VW'(word_q);

  // tables
  logic [ROWW-1:0]   wt_rd, dt_rd, wt_wr, dt_wr;
  logic [CW-1:0]     tt_rd, dtot_rd, tt_wr, dtot_wr;
  logic [CumW-1:0]   cum_rd, cum_wr;
  logic              tab_we, wt_we, dt_we, tt_we, dtot_we;
  logic [VW-1:0]     wt_addr;
  logic [DW-1:0]     dt_addr;
  logic [TW-1:0]     tt_addr;
  logic              up_dir;

  assign tab_we  = (cmd == CMD_DEC_WR) || (cmd == CMD_INC_WR);
  assign up_dir  = (cmd == CMD_INC_WR);
  assign wt_we   = clearing ? (32'(clr_q) < VOCAB_MAX) : tab_we;
  assign dt_we   = clearing ? (32'(clr_q) < DOCS_MAX) : tab_we;
  assign dtot_we = dt_we;
  assign tt_we   = clearing ? (32'(clr_q) < TOPICS_MAX) : tab_we;
  assign wt_addr = clearing ? VW'(clr_q) : word_ix;
  assign dt_addr = clearing ? DW'(clr_q) : doc_ix;
  assign tt_addr = clearing ? TW'(clr_q) : ((cmd == CMD_W_RD) ? k_q : topic_q);

  function automatic logic [CW-1:0] adj(input logic [CW-1:0] v, input logic up);
    logic [CW-1:0] r;
    if (up) begin
      r = (v == '1) ? v : v + CW'(1);
    end else begin
      r = (v == '0) ? v : v - CW'(1);
    end
    return r;
  endfunction

  logic [CW-1:0] wt_ent, dt_ent, wt_k, dt_k;
  assign wt_ent = wt_rd[topic_q*CW +: CW];
  assign dt_ent = dt_rd[topic_q*CW +: CW];
  assign wt_k   = wt_rd[k_q*CW +: CW];
  assign dt_k   = dt_rd[k_q*CW +: CW];

  always_comb begin
    wt_wr   = wt_rd;
    dt_wr   = dt_rd;
    wt_wr[topic_q*CW +: CW] = adj(wt_ent, up_dir);
    dt_wr[topic_q*CW +: CW] = adj(dt_ent, up_dir);
    tt_wr   = adj(tt_rd, up_dir);
    dtot_wr = adj(dtot_rd, up_dir);
    if (clearing) begin
      wt_wr   = '0;
      dt_wr   = '0;
      tt_wr   = '0;
      dtot_wr = '0;
    end
  end

  lgts_ram #(.WIDTH(ROWW), .DEPTH(VOCAB_MAX)) u_wt_ram (
    .clk_i, .we_i(wt_we), .addr_i(wt_addr), .wdata_i(wt_wr), .rdata_o(wt_rd)
  );
  lgts_ram #(.WIDTH(ROWW), .DEPTH(DOCS_MAX)) u_dt_ram (
    .clk_i, .we_i(dt_we), .addr_i(dt_addr), .wdata_i(dt_wr), .rdata_o(dt_rd)
  );
  lgts_ram #(.WIDTH(CW), .DEPTH(TOPICS_MAX)) u_tt_ram (
    .clk_i, .we_i(tt_we), .addr_i(tt_addr), .wdata_i(tt_wr), .rdata_o(tt_rd)
  );
  lgts_ram #(.WIDTH(CW), .DEPTH(DOCS_MAX)) u_dtot_ram (
    .clk_i, .we_i(dtot_we), .addr_i(dt_addr), .wdata_i(dtot_wr), .rdata_o(dtot_rd)
  );
  lgts_ram #(.WIDTH(CumW), .DEPTH(TOPICS_MAX)) u_cum_ram (
    .clk_i, .we_i(cmd == CMD_W_ACC), .addr_i(k_q), .wdata_i(cum_wr), .rdata_o(cum_rd)
  );

  // arithmetic
  logic [NCH*16-1:0] b_pad;
  logic [15:0]       b_chunk;
  logic [AW+15:0]    pp;
  logic [DENW-1:0]   den_sum;
  logic [DENW:0]     rs;
  logic              ge;
  logic [WeightW-1:0] weight;
  logic [CumW:0]     acc_sum;
  logic [CumW-1:0]   u_val;
  logic [RandW+19:0] rp_lo, rp_hi;

  assign b_pad   = (NCH*16)'(b_q);
  assign b_chunk = b_pad[j_q*16 +: 16];
  assign pp      = a_q * b_chunk;
  assign den_sum = DENW'({tt_rd, 16'h0}) + DENW'(vbeta_q);
  assign rs      = {r_q, qsh_q[WeightW-1]};
  assign ge      = rs >= {1'b0, den_q};
  assign weight  = sat_q ? '1 : qsh_q;
  assign acc_sum = {1'b0, acc_q} + (CumW+1)'(weight);
  assign cum_wr  = acc_sum[CumW] ? '1 : acc_sum[CumW-1:0];
  assign u_val   = up_q[UPW-1:RandW];
  assign rp_lo   = rnd_q * acc_q[19:0];
  assign rp_hi   = rnd_q * acc_q[39:20];

  always_ff @(posedge clk_i) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_q    <= op_i;
        doc_q   <= doc_index_i;
        word_q  <= word_id_i;
        topic_q <= (32'(old_topic_i) >= 32'(k_eff)) ? klast : TW'(old_topic_i);
        rnd_q   <= rand_value_i;
        vbeta_q <= vocab_q * beta_q;
        acc_q   <= '0;
        k_q     <= '0;
      end
      CMD_REDUCE: begin
        if (32'(doc_q) >= DOCS_MAX) doc_q <= doc_q - DocIdxW'(DOCS_MAX);
        if (32'(word_q) >= VOCAB_MAX) word_q <= word_q - WordIdW'(VOCAB_MAX);
      end
      CMD_W_LOAD: begin
        a_q   <= AW'({wt_k, 16'h0}) + AW'(beta_q);
        b_q   <= AW'({dt_k, 16'h0}) + AW'(alpha_q);
        den_q <= (den_sum == '0) ? DENW'(1) : den_sum;
        p_q   <= '0;
        j_q   <= '0;
      end
      CMD_W_MUL: begin
        p_q <= p_q + (PW'(pp) << (j_q * 16));
        j_q <= j_q + JW'(1);
      end
      CMD_W_CHK: begin
        sat_q <= CMPW'(p_q) >= (CMPW'(den_q) << 24);
        r_q   <= DENW'(p_q >> 24);
        qsh_q <= {p_q[23:0], 8'h0};
        st_q  <= '0;
      end
      CMD_W_DIV: begin
        r_q   <= ge ? DENW'(rs - {1'b0, den_q}) : DENW'(rs);
        qsh_q <= {qsh_q[WeightW-2:0], ge};
        st_q  <= st_q + 5'd1;
      end
      CMD_W_ACC: begin
        acc_q <= cum_wr;
        if (k_q != klast) k_q <= k_q + TW'(1);
      end
      CMD_R_MUL0: begin
        up_q <= UPW'(rp_lo);
        k_q  <= '0;
      end
      CMD_R_MUL1: begin
        up_q <= up_q + (UPW'(rp_hi) << 20);
      end
      CMD_S_CMP: begin
        if (cum_rd > u_val) begin
          topic_q <= k_q;
        end else if (k_q == klast) begin
          topic_q <= klast;
        end else begin
          k_q <= k_q + TW'(1);
        end
      end
      CMD_OUT: begin
        out_topic_q <= TopicW'(topic_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_topic_o = out_topic_q;

  assign stat_o.clear_done  = clr_done_q;
  assign stat_o.reduce_done = (32'(doc_q) < DOCS_MAX) && (32'(word_q) < VOCAB_MAX);
  assign stat_o.resample    = op_q;
  assign stat_o.mul_done    = (32'(j_q) == NCH - 1);
  assign stat_o.div_done    = (st_q == 5'd31);
  assign stat_o.k_last      = (k_q == klast);
  assign stat_o.found       = (cum_rd > u_val);
  assign stat_o.out_busy    = out_valid_q;

endmodule

// ===== design/lgts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_ctrl
// sequencer for table updates, weight pass and cumulative search
// ----------------------------------------------------------------------------
module lgts_ctrl
  import lgts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output dp_ctrl_t ctrl_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_REDUCE, ST_DEC_RD, ST_DEC_WR, ST_W_RD, ST_W_LOAD,
    ST_W_MUL, ST_W_CHK, ST_W_DIV, ST_W_ACC, ST_R_MUL0, ST_R_MUL1, ST_S_RD,
    ST_S_CMP, ST_INC_RD, ST_INC_WR, ST_OUT
  } state_e;

  state_e state_q, state_d;
  dp_cmd_e cmd;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd     = CMD_NONE;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clear_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd     = CMD_LOAD;
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd = CMD_REDUCE;
        if (stat_i.reduce_done) state_d = stat_i.resample ? ST_DEC_RD : ST_INC_RD;
      end
      ST_DEC_RD: begin cmd = CMD_ADJ_RD; state_d = ST_DEC_WR; end
      ST_DEC_WR: begin cmd = CMD_DEC_WR; state_d = ST_W_RD; end
      ST_W_RD:   begin cmd = CMD_W_RD;   state_d = ST_W_LOAD; end
      ST_W_LOAD: begin cmd = CMD_W_LOAD; state_d = ST_W_MUL; end
      ST_W_MUL: begin
        cmd = CMD_W_MUL;
        if (stat_i.mul_done) state_d = ST_W_CHK;
      end
      ST_W_CHK:  begin cmd = CMD_W_CHK; state_d = ST_W_DIV; end
      ST_W_DIV: begin
        cmd = CMD_W_DIV;
        if (stat_i.div_done) state_d = ST_W_ACC;
      end
      ST_W_ACC: begin
        cmd     = CMD_W_ACC;
        state_d = stat_i.k_last ? ST_R_MUL0 : ST_W_RD;
      end
      ST_R_MUL0: begin cmd = CMD_R_MUL0; state_d = ST_R_MUL1; end
      ST_R_MUL1: begin cmd = CMD_R_MUL1; state_d = ST_S_RD; end
      ST_S_RD:   begin cmd = CMD_S_RD;   state_d = ST_S_CMP; end
      ST_S_CMP: begin
        cmd     = CMD_S_CMP;
        state_d = (stat_i.found || stat_i.k_last) ? ST_INC_RD : ST_S_RD;
      end
      ST_INC_RD: begin cmd = CMD_ADJ_RD; state_d = ST_INC_WR; end
      ST_INC_WR: begin cmd = CMD_INC_WR; state_d = ST_OUT; end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd     = CMD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.cmd = cmd;

endmodule

// ===== design/lda_gibbs_topic_sampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler_top
// lda collapsed gibbs sampler: count tables, topic weighing and draw
// ----------------------------------------------------------------------------
// add transaction: the token is taken, reduced, its counts incremented, then the result is offered
// resample: the old topic's counts are decremented, then each of the K topics in
//   use is weighed with a multiply over 16-bit chunks and a bit-serial divide, then
//   the search reads the cumulative sums in turn; one transaction at a time
// after reset the count tables are cleared to zero while s_axis_tready stays low
module lda_gibbs_topic_sampler_top
  import lgts_pkg::*;
#(
  parameter int TOPICS_MAX = 128,
  parameter int VOCAB_MAX  = 65536,
  parameter int DOCS_MAX   = 4096,
  parameter int COUNT_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // doc_index, word_id, old_topic, rand_value
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // new_topic
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PriorW-1:0]   cfg_data_i
);

  dp_ctrl_t          ctrl;
  dp_stat_t          stat;
  logic [TopicW-1:0] new_topic;

  lgts_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  lgts_datapath #(
    .TOPICS_MAX (TOPICS_MAX),
    .VOCAB_MAX  (VOCAB_MAX),
    .DOCS_MAX   (DOCS_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .op_i         (s_axis_tuser[0]),
    .doc_index_i  (s_axis_tdata[11:0]),
    .word_id_i    (s_axis_tdata[27:12]),
    .old_topic_i  (s_axis_tdata[34:28]),
    .rand_value_i (s_axis_tdata[65:35]),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .new_topic_o  (new_topic)
  );

  assign m_axis_tdata = {1'b0, new_topic};

endmodule

// ===== design/lgts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgts_checker
// port level checks of the topic sampler
// ----------------------------------------------------------------------------
module lgts_checker
  import lgts_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[OutDataW-1])
    else $error("topic pad bit set");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

endmodule

bind lda_gibbs_topic_sampler_top lgts_checker u_lgts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the lda gibbs topic sampler: token adds and resamples are
// streamed in with random gaps and back-pressure. The new topic of every
// transaction is predicted from a local copy of the count tables and the
// configuration, and compared in order with the block's output.
// ----------------------------------------------------------------------------
module tb_top;
  import lgts_pkg::*;

  localparam int                TopicsMax = 128;
  localparam int                DocsMax   = 4096;
  localparam int                CountMax  = (1 << 24) - 1;
  localparam logic [63:0]       CumMax    = 64'hFF_FFFF_FFFF;
  localparam logic [127:0]      WeightMax = 128'hFFFF_FFFF;
  localparam int                StallMax  = 200000;
  localparam bit                OpAdd     = 1'b0;
  localparam bit                OpResample = 1'b1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [PriorW-1:0]   cfg_data_i = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lda_gibbs_topic_sampler_top i_dut (.*);

  // predicted model state
  bit [23:0]   word_cnt [int];
  bit [23:0]   doc_cnt [int];
  bit [23:0]   topic_sum [TopicsMax];
  bit [23:0]   doc_sum [DocsMax];
  logic [7:0]  k_reg = NumTopicsRst;
  logic [16:0] vocab_reg = VocabRst;
  logic [23:0] alpha_reg = AlphaRst;
  logic [23:0] beta_reg = BetaRst;

  logic [6:0]  topic_q [$];
  bit          quiet = 1'b0;
  int          n_sent = 0, n_resample = 0, n_results = 0, n_errors = 0, n_cfg = 0;
  int          stall_cnt = 0;

  function automatic bit [23:0] sat_step(bit [23:0] v, bit up);
    if (up) return (v == CountMax) ? v : 24'(v + 1);
    return (v == 0) ? v : 24'(v - 1);
  endfunction

  function automatic void bump_counts(int w, int d, int t, bit up);
    int wk, dk;
    wk = w * TopicsMax + t;
    dk = d * TopicsMax + t;
    word_cnt[wk] = sat_step(word_cnt.exists(wk) ? word_cnt[wk] : 24'd0, up);
    doc_cnt[dk]  = sat_step(doc_cnt.exists(dk) ? doc_cnt[dk] : 24'd0, up);
    topic_sum[t] = sat_step(topic_sum[t], up);
    doc_sum[d]   = sat_step(doc_sum[d], up);
  endfunction

  // draws the new topic and updates the count tables
  function automatic logic [6:0] draw_topic(bit op, int d, int w, int t, logic [30:0] rnd);
    int           k_use, wk, dk, pick;
    logic [63:0]  acc;
    logic [63:0]  cum [TopicsMax];
    logic [127:0] a, b, den, q, u;
    k_use = (k_reg == 0) ? 1 : (k_reg > TopicsMax) ? TopicsMax : k_reg;
    if (t >= k_use) t = k_use - 1;
    if (op == OpResample) begin
      bump_counts(w, d, t, 1'b0);
      acc = 0;
      for (int k = 0; k < k_use; k++) begin
        wk = w * TopicsMax + k;
        dk = d * TopicsMax + k;
        a = ((word_cnt.exists(wk) ? 128'(word_cnt[wk]) : 128'd0) << 16) + beta_reg;
        b = ((doc_cnt.exists(dk) ? 128'(doc_cnt[dk]) : 128'd0) << 16) + alpha_reg;
        den = (128'(topic_sum[k]) << 16) + 128'(vocab_reg) * beta_reg;
        if (den == 0) den = 1;
        q = ((a * b) << 8) / den;
        if (q > WeightMax) q = WeightMax;
        acc = acc + q[63:0];
        if (acc > CumMax) acc = CumMax;
        cum[k] = acc;
      end
      u = (128'(rnd) * cum[k_use-1]) >> 31;
      pick = k_use - 1;
      for (int k = 0; k < k_use; k++) begin
        if (cum[k] > u) begin
          pick = k;
          break;
        end
      end
      t = pick;
    end
    bump_counts(w, d, t, 1'b1);
    return t[6:0];
  endfunction

  task automatic send_token(bit op, int d, int w, int t, logic [30:0] rnd);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 10) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {6'd0, rnd, t[6:0], w[15:0], d[11:0]};
    #1;
    while (!s_axis_tready) begin
      @(posedge clk_i);
      #1;
    end
    @(posedge clk_i);
    topic_q = {topic_q, draw_topic(op, d[11:0], w[15:0], t[6:0], rnd)};
    n_sent++;
    if (op == OpResample) n_resample++;
    fork
      begin
        @(negedge clk_i);
        if (s_axis_tvalid && n_sent == n_sent) s_axis_tvalid = s_axis_tvalid;
      end
    join_none
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (topic_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value[PriorW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_NUM_TOPICS: k_reg = value[7:0];
      CFG_VOCAB_SIZE: vocab_reg = value[16:0];
      CFG_ALPHA:      alpha_reg = value[23:0];
      CFG_BETA:       beta_reg = value[23:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  function automatic logic [30:0] rnd31();
    return 31'($urandom);
  endfunction

  task automatic test_directed();
    // empty tables: resample decrements at zero, all topics weigh the same
    send_token(OpResample, 0, 0, 0, 31'd0);
    send_token(OpResample, 0, 0, 0, 31'h7FFF_FFFF);
    send_token(OpAdd, 4095, 65535, 127, 31'h4000_0000);
    send_token(OpResample, 4095, 65535, 127, 31'h7FFF_FFFF);
    send_token(OpAdd, 1, 2, 3, 31'd0);
    send_token(OpAdd, 1, 2, 3, 31'd0);
    send_token(OpResample, 1, 2, 3, 31'h0000_0001);
    send_token(OpResample, 1, 2, 98, 31'h5555_5555);
    send_token(OpResample, 1, 2, 99, 31'h2AAA_AAAA);
    drain();
  endtask

  task automatic test_config_extremes();
    // a single topic in use, every topic folds onto it
    write_reg(CFG_NUM_TOPICS, 0);
    send_token(OpAdd, 7, 9, 127, rnd31());
    send_token(OpResample, 7, 9, 64, rnd31());
    drain();
    write_reg(CFG_NUM_TOPICS, 255);
    write_reg(CFG_VOCAB_SIZE, 1);
    write_reg(CFG_ALPHA, 1);
    write_reg(CFG_BETA, 1);
    send_token(OpAdd, 7, 9, 127, rnd31());
    send_token(OpResample, 7, 9, 127, rnd31());
    send_token(OpResample, 7, 9, 0, 31'h7FFF_FFFF);
    drain();
    write_reg(CFG_NUM_TOPICS, 128);
    write_reg(CFG_VOCAB_SIZE, 131071);
    write_reg(CFG_ALPHA, 24'hFF_FFFF);
    write_reg(CFG_BETA, 24'hFF_FFFF);
    send_token(OpResample, 3, 5, 17, rnd31());
    drain();
    write_reg(CFG_VOCAB_SIZE, 0);
    write_reg(CFG_BETA, 0);
    send_token(OpResample, 3, 5, 17, rnd31());
    drain();
    write_reg(CFG_NUM_TOPICS, 1);
    write_reg(CFG_VOCAB_SIZE, 65536);
    send_token(OpResample, 2, 2, 0, rnd31());
    drain();
  endtask

  task automatic test_random_corpus();
    int k, d, w, t;
    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph == 4);
      k = (ph == 7) ? 100 : $urandom_range(8, 2);
      write_reg(CFG_NUM_TOPICS, (ph == 9) ? $urandom_range(255, 129) : k);
      write_reg(CFG_VOCAB_SIZE, $urandom_range(65536, 1));
      write_reg(CFG_ALPHA, $urandom_range(200000, 1));
      write_reg(CFG_BETA, $urandom_range(20000, 1));
      if (ph == 9) k = TopicsMax;
      for (int i = 0; i < ((k > 8) ? 6 : 93); i++) begin
        if ($urandom_range(9) == 0) begin
          // noise: any field value, any op
          send_token($urandom_range(1), $urandom_range(4095), $urandom_range(65535),
                     $urandom_range(127), rnd31());
        end else begin
          // add a token then resample it, with few docs and words
          d = $urandom_range(3) ? $urandom_range(3) : $urandom_range(4095);
          w = $urandom_range(3) ? $urandom_range(7) : $urandom_range(65535);
          t = $urandom_range(k - 1);
          send_token(OpAdd, d, w, t, rnd31());
          send_token(OpResample, d, w, t, rnd31());
        end
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  always @(negedge clk_i) m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (topic_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transaction %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata != {1'b0, topic_q[0]}) begin
          n_errors++;
          if (n_errors <= 10)
            $display("new_topic mismatch: expected %0d actual %0d", topic_q[0], m_axis_tdata);
        end
        void'(topic_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt > StallMax) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_corpus();
    drain();
    if (topic_q.size() != 0) n_errors++;
    $display("covered %0d tokens (%0d resamples), %0d results, %0d register writes",
             n_sent, n_resample, n_results, n_cfg);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
